// ===== hw/rtl/lzwpc_pkg.sv =====
// Shared constants and types of the LZW pixel compressor.
// No dependencies; every other file of the block but lzwpc_table imports this package.
package lzwpc_pkg;

   localparam int SYM_W            = 8;
   localparam int CODE_W           = 12;
   localparam int FIRST_PAIR_CODE  = 256;
   localparam int DICT_ENTRIES_DEF = 4096;
   // Width of the stream tag kept in every hash slot.
   localparam int EPOCH_W          = 8;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              run_end;
      logic              stream_end;
   } rsp_item_type;

endpackage

// ===== hw/rtl/lzwpc_table.sv =====
// Hash table storage of the LZW pixel compressor: one write port and one
// read port with registered read data. Depends on nothing but its parameters.
module lzwpc_table #(
   parameter int AW = 13,
   parameter int DW = 40
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:(1 << AW)-1];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lzwpc_out_stage.sv =====
// Result register of the LZW pixel compressor, holding one transaction.
// Depends on lzwpc_pkg for the result item type.
module lzwpc_out_stage
   import lzwpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rsp_item_type      push,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_run_end,
   output logic              rsp_stream_end
);

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff;
   logic              run_end_ff;
   logic              stream_end_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push.valid) begin
         code_ff       <= push.code;
         run_end_ff    <= push.run_end;
         stream_end_ff <= push.stream_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code       = code_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_stream_end = stream_end_ff;

endmodule

// ===== hw/rtl/lzw_pixel_compressor.sv =====
// Top level of the LZW pixel compressor: sequencer, hash table and result register.
// Depends on lzwpc_pkg, lzwpc_table and lzwpc_out_stage.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | req_symbol[7:0], req_final_req
//   rsp_    | out       | rsp_valid/rsp_ready | rsp_code[11:0], rsp_run_end, rsp_stream_end
//
// A symbol that starts a prefix only loads the prefix. Any other symbol is looked up with
// S_ISSUE (table read) and S_LOOK (compare) per hash probe; a miss passes S_EMIT to emit,
// a final symbol S_FLUSH to flush. The hash table uses linear probing, and a new symbol
// is taken only in S_IDLE. After reset, and after every 255th stream end, a clearing
// pass writes every table slot while req_ready is low. A stalled result register holds
// the sequencer only when it has a further result to emit.
module lzw_pixel_compressor
   import lzwpc_pkg::*;
#(
   parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_final_req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_run_end,
   output logic              rsp_stream_end
);

   localparam int CW = $clog2(DICT_ENTRIES);
   localparam int NW = $clog2(DICT_ENTRIES + 1);
   localparam int AW = CW + 1;
   localparam int DW = EPOCH_W + CW + SYM_W + CW;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ISSUE = 6'b000100,
      S_LOOK  = 6'b001000,
      S_EMIT  = 6'b010000,
      S_FLUSH = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [AW-1:0]      probe_ff, probe_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [NW-1:0]      nfc_ff, nfc_in;
   logic [CW-1:0]      prefix_ff, prefix_in;
   logic               pv_ff, pv_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               fin_ff, fin_in;
   logic [CODE_W-1:0]  emit_ff, emit_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DW-1:0]      wr_data;
   logic [DW-1:0]      rd_data;
   logic [EPOCH_W-1:0] slot_tag;
   logic [CW-1:0]      slot_prefix;
   logic [SYM_W-1:0]   slot_sym;
   logic [CW-1:0]      slot_code;
   logic               slot_used, slot_hit, room, out_free, accept;
   rsp_item_type       push;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign slot_tag    = rd_data[DW-1 -: EPOCH_W];
   assign slot_prefix = rd_data[CW+SYM_W+CW-1 -: CW];
   assign slot_sym    = rd_data[CW+SYM_W-1 -: SYM_W];
   assign slot_code   = rd_data[CW-1:0];
   // A slot belongs to the current stream only if its tag matches the epoch.
   assign slot_used   = (slot_tag == epoch_ff);
   assign slot_hit    = slot_used && (slot_prefix == prefix_ff) && (slot_sym == sym_ff);
   assign room        = (nfc_ff < NW'(DICT_ENTRIES));

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      probe_in  = probe_ff;
      epoch_in  = epoch_ff;
      nfc_in    = nfc_ff;
      prefix_in = prefix_ff;
      pv_in     = pv_ff;
      sym_in    = sym_ff;
      fin_in    = fin_ff;
      emit_in   = emit_ff;
      wr_en     = 1'b0;
      wr_addr   = probe_ff;
      wr_data   = {epoch_ff, prefix_ff, sym_ff, CW'(nfc_ff)};
      push      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               epoch_in = EPOCH_W'(1);
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               sym_in   = req_symbol;
               fin_in   = req_final_req;
               probe_in = AW'(prefix_ff) ^ (AW'(req_symbol) << (AW - SYM_W));
               if (!pv_ff) begin
                  prefix_in = CW'(req_symbol);
                  pv_in     = 1'b1;
                  if (req_final_req) begin
                     state_in = S_FLUSH;
                  end
               end else begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (slot_hit) begin
               prefix_in = slot_code;
               state_in  = fin_ff ? S_FLUSH : S_IDLE;
            end else if (slot_used) begin
               probe_in = probe_ff + AW'(1);
               state_in = S_ISSUE;
            end else begin
               // Empty slot ends the probe: emit the prefix and, if the dictionary has room, insert the pair here.
               emit_in   = CODE_W'(prefix_ff);
               prefix_in = CW'(sym_ff);
               if (room) begin
                  wr_en  = 1'b1;
                  nfc_in = nfc_ff + NW'(1);
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               push.valid      = 1'b1;
               push.code       = emit_ff;
               push.run_end    = !fin_ff;
               push.stream_end = 1'b0;
               state_in        = fin_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               push.valid      = 1'b1;
               push.code       = CODE_W'(prefix_ff);
               push.run_end    = 1'b1;
               push.stream_end = 1'b1;
               prefix_in       = '0;
               pv_in           = 1'b0;
               nfc_in          = NW'(FIRST_PAIR_CODE);
               epoch_in        = epoch_ff + EPOCH_W'(1);
               state_in        = (epoch_ff == {EPOCH_W{1'b1}}) ? S_CLEAR : S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         epoch_ff  <= EPOCH_W'(1);
         nfc_ff    <= NW'(FIRST_PAIR_CODE);
         prefix_ff <= '0;
         pv_ff     <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         epoch_ff  <= epoch_in;
         nfc_ff    <= nfc_in;
         prefix_ff <= prefix_in;
         pv_ff     <= pv_in;
         fin_ff    <= fin_in;
      end
      probe_ff <= probe_in;
      sym_ff   <= sym_in;
      emit_ff  <= emit_in;
   end

   lzwpc_table #(
      .AW (AW),
      .DW (DW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (probe_ff),
      .rd_data (rd_data)
   );

   lzwpc_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code       (rsp_code),
      .rsp_run_end    (rsp_run_end),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

// ===== hw/rtl/lzwpc_checker.sv =====
// Port-level checks of the LZW pixel compressor, bound to the top level.
// Depends on lzw_pixel_compressor and lzwpc_pkg.
module lzwpc_checker
   import lzwpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_final_req,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CODE_W-1:0] rsp_code,
   input logic              rsp_run_end,
   input logic              rsp_stream_end
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code)
         && $stable(rsp_run_end) && $stable(rsp_stream_end))
      else $error("stalled result changed");

   // A result that ends a stream always also ends a run.
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_end)
      else $error("stream end without run end");

   // A final symbol must be flushed before another symbol is taken.
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_req |=> !req_ready)
      else $error("input taken during flush");

   // Reset empties the result register and starts the clearing pass.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("reset state wrong");

endmodule

bind lzw_pixel_compressor lzwpc_checker u_lzwpc_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for lzw_pixel_compressor: queued pixel streams, a clocked
// driver and monitor, and a code predictor with its own dictionary.
// Depends on lzwpc_pkg and the lzw_pixel_compressor RTL.
module tb;
   import lzwpc_pkg::*;

   localparam int DICT_CAP    = DICT_ENTRIES_DEF;
   localparam int PAIR_KEY_W  = CODE_W + SYM_W;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_AT     = 100;
   localparam int STALL_LIMIT = 100000;
   localparam int TAIL_CYCLES = 64;
   localparam int MAX_REPORTS = 40;
   localparam int PHASE_ITEMS = 300;
   localparam int FILL_ITEMS  = 180;

   typedef enum int {MODE_NOISE, MODE_NARROW, MODE_EXTREME, MODE_FLAT} pixel_mode_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             final_req;
   } pixel_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              run_end;
      logic              stream_end;
   } code_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [SYM_W-1:0]  req_symbol     = '0;
   logic              req_final_req  = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [CODE_W-1:0] rsp_code;
   logic              rsp_run_end;
   logic              rsp_stream_end;

   pixel_type pending_pixels[$];
   code_type  expected_codes[$];
   int     pixels_queued   = 0;
   int     pixels_accepted = 0;
   int     codes_seen      = 0;
   int     errors          = 0;
   int     send_idle_pct   = 0;
   int     rcv_stall_pct   = 0;
   int     hold_left       = 0;
   int     quiet_cycles    = 0;

   // Predictor state. A pair entry is live only when tagged with the current
   // stream number, which stands in for clearing the table at every stream end.
   bit [CODE_W-1:0] lut_code   [0:(1 << PAIR_KEY_W) - 1];
   int unsigned     lut_stream [0:(1 << PAIR_KEY_W) - 1];
   int unsigned     stream_id   = 1;
   int unsigned     next_code   = FIRST_PAIR_CODE;
   bit [CODE_W-1:0] cur_prefix  = '0;
   bit              have_prefix = 1'b0;

   lzw_pixel_compressor #(.DICT_ENTRIES(DICT_CAP)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_symbol     (req_symbol),
      .req_final_req  (req_final_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code       (rsp_code),
      .rsp_run_end    (rsp_run_end),
      .rsp_stream_end (rsp_stream_end)
   );

   always #10 clock = ~clock;

   function automatic void predict_codes(input logic [SYM_W-1:0] sym, input logic fin);
      bit [PAIR_KEY_W-1:0] key;
      code_type            emitted;
      key = {cur_prefix, sym};
      if (!have_prefix) begin
         cur_prefix  = CODE_W'(sym);
         have_prefix = 1'b1;
      end else if (lut_stream[key] == stream_id) begin
         cur_prefix = lut_code[key];
      end else begin
         emitted = '{code: cur_prefix, run_end: !fin, stream_end: 1'b0};
         expected_codes = {expected_codes, emitted};
         if (next_code < DICT_CAP) begin
            lut_stream[key] = stream_id;
            lut_code[key]   = CODE_W'(next_code);
            next_code++;
         end
         cur_prefix = CODE_W'(sym);
      end
      if (fin) begin
         emitted = '{code: cur_prefix, run_end: 1'b1, stream_end: 1'b1};
         expected_codes = {expected_codes, emitted};
         cur_prefix  = '0;
         have_prefix = 1'b0;
         next_code   = FIRST_PAIR_CODE;
         stream_id++;
      end
   endfunction

   function automatic void note_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endfunction

   // Driver: offers the next queued pixel when the channel is free, idling at random by send_idle_pct.
   always @(posedge clock) begin : driver
      pixel_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_codes(req_symbol, req_final_req);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_pixels.pop_front();
               req_valid     <= 1'b1;
               req_symbol    <= item.symbol;
               req_final_req <= item.final_req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted code and drives the receiver's back-pressure.
   always @(posedge clock) begin : monitor
      code_type want;
      bit       start_hold;
      start_hold = 1'b0;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            codes_seen++;
            start_hold = (codes_seen == HOLD_AT);
            if (expected_codes.size() == 0) begin
               note_mismatch("unexpected code", -1, int'(rsp_code));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_code !== want.code)
                  note_mismatch("code", int'(want.code), int'(rsp_code));
               if (rsp_run_end !== want.run_end)
                  note_mismatch("run_end", int'(want.run_end), int'(rsp_run_end));
               if (rsp_stream_end !== want.stream_end)
                  note_mismatch("stream_end", int'(want.stream_end), int'(rsp_stream_end));
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (start_hold) begin
            rsp_ready <= 1'b0;
            hold_left <= LONG_HOLD;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   // A stall of both channels ends the run; a flood of wrong results keeps the channel busy, so it ends the run too.
   always @(posedge clock) begin
      if (errors > MAX_REPORTS) begin
         $display("tb: FAIL");
         $finish;
      end else if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_pixel(input logic [SYM_W-1:0] sym, input logic fin);
      pixel_type item;
      item = '{symbol: sym, final_req: fin};
      pending_pixels = {pending_pixels, item};
      pixels_queued++;
   endtask

   task automatic queue_stream(input pixel_mode_type mode, input int len);
      logic [SYM_W-1:0] base;
      logic [SYM_W-1:0] sym;
      base = SYM_W'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
         case (mode)
            MODE_NOISE:   sym = SYM_W'($urandom_range(255));
            MODE_NARROW:  sym = base + SYM_W'($urandom_range(3));
            MODE_EXTREME: sym = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            default:      sym = base;
         endcase
         queue_pixel(sym, i == len - 1);
      end
   endtask

   // Mostly short streams, so that the stream count passes the hash table's
   // tag wrap and its clearing pass is exercised.
   task automatic queue_random_streams(input int n_items);
      int goal;
      int len;
      int pick;
      goal = pixels_queued + n_items;
      while (pixels_queued < goal) begin
         pick = $urandom_range(99);
         if (pick < 90)
            len = $urandom_range(1, 3);
         else if (pick < 98)
            len = $urandom_range(4, 12);
         else
            len = $urandom_range(16, 48);
         queue_stream(pixel_mode_type'($urandom_range(3)), len);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pixels_accepted != pixels_queued || expected_codes.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int send_pct[4];
      int rcv_pct[4];
      send_pct = '{0, 75, 0, 31};
      rcv_pct  = '{0, 0, 75, 31};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Single-symbol streams flush straight from an empty prefix.
      queue_pixel(8'h00, 1'b1);
      queue_pixel(8'hFF, 1'b1);
      // A flat run builds ever longer prefixes through dictionary hits.
      for (int i = 0; i < 7; i++)
         queue_pixel(8'h07, i == 6);
      for (int i = 0; i < 6; i++)
         queue_pixel(i[0] ? 8'hFF : 8'h00, i == 5);
      for (int i = 0; i < 8; i++)
         queue_pixel(i[1] ? 8'h00 : 8'hFF, i == 7);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         rcv_stall_pct = rcv_pct[p];
         queue_random_streams(PHASE_ITEMS);
         wait_drained();
      end

      // One long noisy stream grows the dictionary well past the short streams.
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      queue_stream(MODE_NOISE, FILL_ITEMS);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && expected_codes.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== lzw_pixel_compressor.f =====
hw/rtl/lzwpc_pkg.sv
hw/rtl/lzwpc_table.sv
hw/rtl/lzwpc_out_stage.sv
hw/rtl/lzw_pixel_compressor.sv
hw/rtl/lzwpc_checker.sv
dv/tb.sv
